FILE: src/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the coin and credit controller.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // Seats scanned by the START opcode; only four START bits exist.
  localparam int SEATS      = 4;
  localparam int START_BITS = 4;
  localparam int SCAN_SEATS = (SEATS < START_BITS) ? SEATS : START_BITS;

  localparam logic [7:0]  CREDIT_CEIL = 8'h63;
  localparam logic [15:0] HOLD_LIMIT  = 16'h0360;
  localparam logic [3:0]  GAP_MIN     = 4'd4;
  localparam logic [3:0]  GAP_MAX     = 4'd10;

  // Opcodes
  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_START   = 4'd1;
  localparam logic [3:0] OP_JOIN    = 4'd2;
  localparam logic [3:0] OP_BUYIN   = 4'd3;
  localparam logic [3:0] OP_CONT    = 4'd4;
  localparam logic [3:0] OP_SEAT    = 4'd5;
  localparam logic [3:0] OP_SET     = 4'd6;
  localparam logic [3:0] OP_REFRESH = 4'd7;
  localparam logic [3:0] OP_FORCE   = 4'd8;

  // Price bit positions in price_by_credit
  localparam logic [1:0] PRICE_JOIN  = 2'd0;
  localparam logic [1:0] PRICE_BUYIN = 2'd1;
  localparam logic [1:0] PRICE_CONT  = 2'd2;

  typedef struct packed {
    logic [7:0] coins_per_credit;
    logic [7:0] credits_per_coin;
    logic [2:0] price_by_credit;
  } cfg_t;

  typedef struct packed {
    logic [1:0][15:0] hold_frames;
    logic [1:0][3:0]  gap_frames;
    logic [7:0]       coin_count;
    logic [7:0]       credit_store;
    logic [15:0]      credit_total;
    logic [15:0]      coin_total;
    logic [15:0]      shown_word;
    logic             redraw_pending;
  } state_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [1:0] chute_pressed;
    logic [3:0] start_pressed;
    logic [7:0] new_credits;
  } in_word_t;

  typedef struct packed {
    logic        taken;
    logic [2:0]  seat;
    logic [7:0]  credit_count;
    logic [7:0]  part_coins;
    logic        can_afford;
    logic [1:0]  coins_registered;
    logic        display_update;
    logic [15:0] display_word;
    logic [15:0] total_credits;
    logic [15:0] total_coins;
  } out_word_t;

endpackage

FILE: src/ccc_chan_if.sv
// ----------------------------------------------------------------------------
// ccc_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ccc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ccc_step.sv
// ----------------------------------------------------------------------------
// ccc_step
// Combinational update of the controller state for one input word.
// ----------------------------------------------------------------------------
module ccc_step
  import ccc_pkg::*;
(
  input  cfg_t      cfg,
  input  state_t    state,
  input  in_word_t  word,
  output state_t    state_next,
  output out_word_t result
);

  function automatic state_t accept_coin(state_t s, cfg_t c);
    state_t     r;
    logic [7:0] cc;
    logic [8:0] sum;
    r            = s;
    cc           = s.coin_count + 8'd1;
    r.coin_total = s.coin_total + 16'd1;
    sum          = {1'b0, s.credit_store} + {1'b0, c.credits_per_coin};
    if (c.coins_per_credit > cc) begin
      r.coin_count = cc;
    end else if (sum >= {1'b0, CREDIT_CEIL}) begin
      r.credit_store = CREDIT_CEIL;
      r.coin_count   = '0;
    end else begin
      r.credit_store = sum[7:0];
      r.credit_total = s.credit_total + {8'd0, c.credits_per_coin};
      r.coin_count   = cc - c.coins_per_credit;
    end
    return r;
  endfunction

  function automatic state_t qualify(state_t s, cfg_t c, logic idx, logic down,
                                     output logic hit);
    state_t r;
    r   = s;
    hit = 1'b0;
    if (down) begin
      r.hold_frames[idx] = s.hold_frames[idx] + 16'd1;
    end else if (s.hold_frames[idx] == '0) begin
      if (s.gap_frames[idx] < GAP_MAX) r.gap_frames[idx] = s.gap_frames[idx] + 4'd1;
    end else if (s.gap_frames[idx] < GAP_MIN || s.hold_frames[idx] >= HOLD_LIMIT) begin
      r.hold_frames[idx] = '0;
    end else begin
      r                  = accept_coin(s, c);
      r.gap_frames[idx]  = '0;
      r.hold_frames[idx] = '0;
      hit                = 1'b1;
    end
    return r;
  endfunction

  function automatic state_t take_credit(state_t s, output logic ok);
    state_t r;
    r  = s;
    ok = 1'b0;
    if (s.credit_store != '0) begin
      r.credit_store   = s.credit_store - 8'd1;
      r.redraw_pending = 1'b1;
      ok               = 1'b1;
    end
    return r;
  endfunction

  function automatic state_t take_unit(state_t s, cfg_t c, logic [1:0] pbit,
                                       output logic ok);
    state_t r;
    r  = s;
    ok = 1'b0;
    if (c.price_by_credit[pbit]) begin
      r = take_credit(s, ok);
    end else if (s.coin_count != '0) begin
      r.coin_count     = s.coin_count - 8'd1;
      r.redraw_pending = 1'b1;
      ok               = 1'b1;
    end else if (s.credit_store != '0) begin
      r.credit_store   = s.credit_store - 8'd1;
      r.coin_count     = c.coins_per_credit - 8'd1;
      r.redraw_pending = 1'b1;
      ok               = 1'b1;
    end
    return r;
  endfunction

  state_t      s0;
  state_t      s1;
  logic        hit0;
  logic        hit1;
  logic        taken;
  logic [2:0]  seat;
  logic        upd;
  logic        found;
  logic [15:0] disp;

  always_comb begin
    s0    = state;
    s1    = state;
    hit0  = 1'b0;
    hit1  = 1'b0;
    taken = 1'b0;
    seat  = '0;
    upd   = 1'b0;
    found = 1'b0;
    disp  = {state.coin_count, state.credit_store};
    state_next = state;
    case (word.opcode)
      OP_TICK: begin
        // chute one settles first, chute two sees its result
        s0         = qualify(state, cfg, 1'b0, word.chute_pressed[0], hit0);
        s1         = qualify(s0, cfg, 1'b1, word.chute_pressed[1], hit1);
        state_next = s1;
      end
      OP_START: begin
        if (state.credit_store != '0) begin
          for (int n = 0; n < SCAN_SEATS; n++) begin
            if (!found && word.start_pressed[n]) begin
              found = 1'b1;
              seat  = 3'(n + 1);
            end
          end
          if (found) state_next.credit_store = state.credit_store - 8'd1;
        end
      end
      OP_JOIN:  state_next = take_unit(state, cfg, PRICE_JOIN, taken);
      OP_BUYIN: state_next = take_unit(state, cfg, PRICE_BUYIN, taken);
      OP_CONT:  state_next = take_unit(state, cfg, PRICE_CONT, taken);
      OP_SEAT:  state_next = take_credit(state, taken);
      OP_SET:   state_next.credit_store = word.new_credits;
      OP_REFRESH: begin
        if (state.redraw_pending || state.shown_word != disp) begin
          state_next.redraw_pending = 1'b0;
          state_next.shown_word     = disp;
          upd                       = 1'b1;
        end
      end
      OP_FORCE: state_next.redraw_pending = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    result.taken            = taken;
    result.seat             = seat;
    result.credit_count     = state_next.credit_store;
    result.part_coins       = state_next.coin_count;
    result.can_afford       = (state_next.coin_count != '0) ||
                              (state_next.credit_store != '0);
    result.coins_registered = {1'b0, hit0} + {1'b0, hit1};
    result.display_update   = upd;
    result.display_word     = {state_next.coin_count, state_next.credit_store};
    result.total_credits    = state_next.credit_total;
    result.total_coins      = state_next.coin_total;
  end

endmodule

FILE: src/coin_credit_controller.sv
// ----------------------------------------------------------------------------
// coin_credit_controller
// Arcade coin chute qualification and credit bookkeeping.
// ----------------------------------------------------------------------------
// Usage:
//   in_word  : one command word per handshake (opcode, chute and START bits,
//              credit load value). Every word yields exactly one result word.
//   out_word : result word with take status, started seat, credit and coin
//              counts, display word and bookkeeping totals.
//   APB port : coins_per_credit at 0x0, credits_per_coin at 0x4,
//              price_by_credit at 0x8. A zero ratio is stored as one.
//              Write only while no word is in flight.
// Flow: an accepted word is registered, evaluated, and its result registered
//   for out_word. Throughput is one word per cycle unless out_word stalls; the
//   whole state update is one logic pass between input and result registers.
// Reset: counters, totals and chute timers clear, a redraw is pending, ratios
//   reset to one coin for one credit with coin pricing everywhere.
// Stall: while out_word is held off, the result register keeps its word and
//   one more word waits in the input register; then in_word drops ready.
// ----------------------------------------------------------------------------
module coin_credit_controller
  import ccc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ccc_chan_if.sink    in_word,
  ccc_chan_if.source  out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register map index (byte address / 4)
  localparam logic [1:0] REG_COINS_PER_CREDIT = 2'd0;
  localparam logic [1:0] REG_CREDITS_PER_COIN = 2'd1;
  localparam logic [1:0] REG_PRICE_BY_CREDIT  = 2'd2;

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  logic      s1_valid;
  in_word_t  s1_word;
  logic      r_valid;
  out_word_t r_word;
  out_word_t result;
  logic      advance;
  logic      cfg_wr;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coins_per_credit <= 8'd1;
      cfg.credits_per_coin <= 8'd1;
      cfg.price_by_credit  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COINS_PER_CREDIT:
          cfg.coins_per_credit <= (pwdata[7:0] == '0) ? 8'd1 : pwdata[7:0];
        REG_CREDITS_PER_COIN:
          cfg.credits_per_coin <= (pwdata[7:0] == '0) ? 8'd1 : pwdata[7:0];
        REG_PRICE_BY_CREDIT:
          cfg.price_by_credit  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COINS_PER_CREDIT: prdata = {24'd0, cfg.coins_per_credit};
      REG_CREDITS_PER_COIN: prdata = {24'd0, cfg.credits_per_coin};
      REG_PRICE_BY_CREDIT:  prdata = {29'd0, cfg.price_by_credit};
      default:              prdata = '0;
    endcase
  end

  // ---- pipeline control ----
  // Move the held word into the result register whenever that register is
  // empty or being drained this cycle; take a new word whenever the input
  // register is empty or empties in the same cycle.
  assign advance       = s1_valid && (!r_valid || out_word.ready);
  assign in_word.ready = !s1_valid || advance;
  assign out_word.valid = r_valid;
  assign out_word.data  = r_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      r_valid  <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        r_valid <= 1'b1;
      end else if (out_word.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold until the next load.
  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      s1_word <= in_word.data;
    end
    if (advance) begin
      r_word <= result;
    end
  end

  // ---- controller state ----
  // Commit the state only when the word actually advances, so a stalled
  // word is never applied twice.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.hold_frames    <= '0;
      state.gap_frames     <= '0;
      state.coin_count     <= '0;
      state.credit_store   <= '0;
      state.credit_total   <= '0;
      state.coin_total     <= '0;
      state.shown_word     <= '0;
      state.redraw_pending <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  ccc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .word       (s1_word),
    .state_next (state_next),
    .result     (result)
  );

endmodule

FILE: test/coin_credit_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_credit_controller_tb
// Self-checking bench for the arcade coin and credit controller.
// Command words go in through a queued driver with random gaps. Each accepted
// word is run through a local model of the chutes, credits and display, and
// the predicted report is queued. A monitor takes every report word that
// leaves the block and compares it field by field with the oldest prediction.
// The run walks through several pricing and ratio settings, each under
// different idle and stall patterns, and includes a long output hold-off.
// ----------------------------------------------------------------------------
module coin_credit_controller_tb;
  import ccc_pkg::*;

  // Register map of the APB port
  localparam logic [3:0] ADDR_COINS_PER_CREDIT = 4'h0;
  localparam logic [3:0] ADDR_CREDITS_PER_COIN = 4'h4;
  localparam logic [3:0] ADDR_PRICE_BY_CREDIT  = 4'h8;

  // Opcodes past the last defined one; the block must ignore them
  localparam logic [3:0] OP_FIRST_UNUSED = OP_FORCE + 4'd1;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ccc_chan_if #(.payload_t(in_word_t))  cmd_ch ();
  ccc_chan_if #(.payload_t(out_word_t)) rpt_ch ();

  coin_credit_controller dut (
    .clk      (clk),
    .rst      (rst),
    .in_word  (cmd_ch),
    .out_word (rpt_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model of the controller: chute timers, coin and credit counters,
  // display bookkeeping and the three rate registers.
  // --------------------------------------------------------------------------
  cfg_t        rates_q;
  logic [15:0] held_q [2];
  logic [3:0]  gap_q [2];
  logic [7:0]  coins_q;
  logic [7:0]  credits_q;
  logic [15:0] credit_sum;
  logic [15:0] coin_sum;
  logic [15:0] shown_q;
  logic        redraw_q;

  // Bench bookkeeping
  in_word_t    commands_waiting [$];
  out_word_t   reports_due [$];
  int          error_count = 0;
  int          words_sent = 0;
  int          reports_checked = 0;
  int          coins_seen = 0;
  int          seats_started = 0;
  int          backpressure_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_asked = 0;
  int          stall_served = 0;
  int          stall_left = 0;
  int          settings_run = 1;

  // Chute press pattern generator: current level and frames left in it
  logic [1:0]  gen_down = 2'b00;
  int          gen_left [2] = '{0, 0};

  // Count one coin in; convert to credits once the coin threshold is met.
  function automatic void add_coin();
    logic [8:0] sum;
    coins_q  = coins_q + 8'd1;
    coin_sum = coin_sum + 16'd1;
    if (rates_q.coins_per_credit > coins_q) return;
    sum = {1'b0, credits_q} + {1'b0, rates_q.credits_per_coin};
    if (sum >= {1'b0, CREDIT_CEIL}) begin
      // Cap reached: clamp credits, drop the part coins, leave the total alone
      credits_q = CREDIT_CEIL;
      coins_q   = 8'd0;
    end else begin
      credits_q  = sum[7:0];
      credit_sum = credit_sum + 16'(rates_q.credits_per_coin);
      coins_q    = coins_q - rates_q.coins_per_credit;
    end
  endfunction

  // Advance one chute by a frame; return 1 when a release qualifies as a coin.
  function automatic logic judge_chute(input int n, input logic down);
    if (down) begin
      held_q[n] = held_q[n] + 16'd1;
      return 1'b0;
    end
    if (held_q[n] == 16'd0) begin
      if (gap_q[n] < GAP_MAX) gap_q[n] = gap_q[n] + 4'd1;
      return 1'b0;
    end
    if (gap_q[n] < GAP_MIN || held_q[n] >= HOLD_LIMIT) begin
      held_q[n] = 16'd0;
      return 1'b0;
    end
    add_coin();
    gap_q[n]  = 4'd0;
    held_q[n] = 16'd0;
    return 1'b1;
  endfunction

  function automatic logic take_credit();
    if (credits_q == 8'd0) return 1'b0;
    credits_q = credits_q - 8'd1;
    redraw_q  = 1'b1;
    return 1'b1;
  endfunction

  // Priced take: whole credit when the price bit is set, else a part coin,
  // breaking a credit into coins when no part coin is left.
  function automatic logic take_at_price(input logic [1:0] price_bit);
    if (rates_q.price_by_credit[price_bit]) return take_credit();
    if (coins_q != 8'd0) begin
      coins_q  = coins_q - 8'd1;
      redraw_q = 1'b1;
      return 1'b1;
    end
    if (credits_q == 8'd0) return 1'b0;
    credits_q = credits_q - 8'd1;
    coins_q   = rates_q.coins_per_credit - 8'd1;
    redraw_q  = 1'b1;
    return 1'b1;
  endfunction

  // Apply one command word to the model and return the report it must cause.
  function automatic out_word_t predict_report(input in_word_t cmd);
    out_word_t   r;
    logic [15:0] face;
    r = '0;
    case (cmd.opcode)
      OP_TICK: begin
        r.coins_registered = 2'(judge_chute(0, cmd.chute_pressed[0]));
        r.coins_registered = r.coins_registered + 2'(judge_chute(1, cmd.chute_pressed[1]));
      end
      OP_START: begin
        for (int n = 0; n < SCAN_SEATS; n++) begin
          if (r.seat == 3'd0 && cmd.start_pressed[n] && credits_q != 8'd0) begin
            credits_q = credits_q - 8'd1;
            r.seat    = 3'(n + 1);
          end
        end
      end
      OP_JOIN:  r.taken = take_at_price(PRICE_JOIN);
      OP_BUYIN: r.taken = take_at_price(PRICE_BUYIN);
      OP_CONT:  r.taken = take_at_price(PRICE_CONT);
      OP_SEAT:  r.taken = take_credit();
      OP_SET:   credits_q = cmd.new_credits;
      OP_REFRESH: begin
        face = {coins_q, credits_q};
        if (redraw_q || shown_q != face) begin
          redraw_q           = 1'b0;
          shown_q            = face;
          r.display_update   = 1'b1;
        end
      end
      OP_FORCE: redraw_q = 1'b1;
      default: ;
    endcase
    r.credit_count  = credits_q;
    r.part_coins    = coins_q;
    r.can_afford    = (coins_q != 8'd0) || (credits_q != 8'd0);
    r.display_word  = {coins_q, credits_q};
    r.total_credits = credit_sum;
    r.total_coins   = coin_sum;
    return r;
  endfunction

  function automatic void apply_rate(input logic [3:0] addr, input logic [31:0] value);
    case (addr)
      ADDR_COINS_PER_CREDIT:
        rates_q.coins_per_credit = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
      ADDR_CREDITS_PER_COIN:
        rates_q.credits_per_coin = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
      ADDR_PRICE_BY_CREDIT:
        rates_q.price_by_credit = value[2:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_report(input out_word_t want, input out_word_t got);
    check_field("taken",            16'(want.taken),            16'(got.taken));
    check_field("seat",             16'(want.seat),             16'(got.seat));
    check_field("credit_count",     16'(want.credit_count),     16'(got.credit_count));
    check_field("part_coins",       16'(want.part_coins),       16'(got.part_coins));
    check_field("can_afford",       16'(want.can_afford),       16'(got.can_afford));
    check_field("coins_registered", 16'(want.coins_registered), 16'(got.coins_registered));
    check_field("display_update",   16'(want.display_update),   16'(got.display_update));
    check_field("display_word",     want.display_word,          got.display_word);
    check_field("total_credits",    want.total_credits,         got.total_credits);
    check_field("total_coins",      want.total_coins,           got.total_coins);
    reports_checked++;
    coins_seen += int'(got.coins_registered);
    if (got.seat != 3'd0) seats_started++;
  endfunction

  // --------------------------------------------------------------------------
  // Command word builders
  // --------------------------------------------------------------------------
  function automatic in_word_t command_word(input logic [3:0] op, input logic [1:0] chutes,
                                            input logic [3:0] starts,
                                            input logic [7:0] credits);
    in_word_t w;
    w.opcode        = op;
    w.chute_pressed = chutes;
    w.start_pressed = starts;
    w.new_credits   = credits;
    return w;
  endfunction

  // Frame tick following a press/release pattern per chute. Presses are
  // mostly short, some longer; releases mostly long enough to qualify the next
  // coin, with some short gaps mixed in so that rejections happen too.
  function automatic in_word_t make_tick();
    in_word_t w;
    w = command_word(OP_TICK, 2'b00, 4'($urandom), 8'($urandom));
    for (int n = 0; n < 2; n++) begin
      if (gen_left[n] == 0) begin
        gen_down[n] = ~gen_down[n];
        if (gen_down[n])
          gen_left[n] = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        else
          gen_left[n] = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      end
      w.chute_pressed[n] = gen_down[n];
      gen_left[n]--;
    end
    return w;
  endfunction

  // Any non-tick opcode with random content; credit loads lean toward the
  // low end and toward the cap so that both limits get hit often.
  function automatic in_word_t make_other();
    in_word_t w;
    int       pick;
    w = command_word(OP_TICK, 2'($urandom), 4'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 12)      w.opcode = OP_START;
    else if (pick < 22) w.opcode = OP_JOIN;
    else if (pick < 32) w.opcode = OP_BUYIN;
    else if (pick < 42) w.opcode = OP_CONT;
    else if (pick < 52) w.opcode = OP_SEAT;
    else if (pick < 64) w.opcode = OP_SET;
    else if (pick < 78) w.opcode = OP_REFRESH;
    else if (pick < 86) w.opcode = OP_FORCE;
    else                w.opcode = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    if (w.opcode == OP_SET) begin
      case ($urandom_range(2))
        0: w.new_credits = 8'($urandom_range(0, 5));
        1: w.new_credits = 8'($urandom_range(95, 100));
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic push_ticks(input logic [1:0] chutes, input int count);
    for (int i = 0; i < count; i++)
      commands_waiting.push_back(command_word(OP_TICK, chutes, 4'($urandom), 8'($urandom)));
  endtask

  // Release both chutes long enough to qualify, hold chute one for the given
  // frames and chute two for one frame more, then release both.
  task automatic push_long_hold(input int frames);
    push_ticks(2'b00, 6);
    push_ticks(2'b11, frames);
    push_ticks(2'b10, 1);
    push_ticks(2'b00, 6);
    gen_down    = 2'b00;
    gen_left[0] = 0;
    gen_left[1] = 0;
  endtask

  // --------------------------------------------------------------------------
  // Command driver: offer the next queued word whenever the channel is free;
  // predict each word at the edge where it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        reports_due.push_back(predict_report(cmd_ch.data));
        words_sent++;
      end
      // Hold a word that is still waiting; otherwise pick the next or idle.
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (commands_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data  <= commands_waiting.pop_front();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted here so the driver keeps offering words.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_asked) begin
      stall_left   <= HOLD_OFF_CYCLES;
      stall_served <= stall_served + 1;
    end
  end

  // Report receiver: random stalls, and never ready during the hold-off window.
  always @(posedge clk) begin
    if (rst) begin
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Report monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left != 0 && cmd_ch.valid && !cmd_ch.ready) backpressure_cycles++;
      if (rpt_ch.valid && rpt_ch.ready) begin
        if (reports_due.size() == 0) begin
          $error("report word 0x%0h arrived with nothing expected", rpt_ch.data);
          error_count++;
        end else begin
          check_report(reports_due.pop_front(), rpt_ch.data);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  // APB write: setup, access, then the register takes the value at the edge
  // where the access phase meets pready.
  task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_rate(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_rates(input logic [7:0] coins, input logic [7:0] credits,
                           input logic [2:0] price);
    write_reg(ADDR_COINS_PER_CREDIT, 32'(coins));
    write_reg(ADDR_CREDITS_PER_COIN, 32'(credits));
    write_reg(ADDR_PRICE_BY_CREDIT, 32'(price));
    settings_run++;
  endtask

  // Wait until every queued word is sent and every report has come back.
  task automatic drain();
    do @(negedge clk);
    while (commands_waiting.size() != 0 || cmd_ch.valid || reports_due.size() != 0);
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55) commands_waiting.push_back(make_tick());
      else                         commands_waiting.push_back(make_other());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input known from time zero.
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rpt_ch.ready = 1'b0;

    // Model state after reset: ratios one to one, coin pricing, redraw due.
    rates_q.coins_per_credit = 8'd1;
    rates_q.credits_per_coin = 8'd1;
    rates_q.price_by_credit  = 3'd0;
    held_q[0]  = '0;
    held_q[1]  = '0;
    gap_q[0]   = '0;
    gap_q[1]   = '0;
    coins_q    = '0;
    credits_q  = '0;
    credit_sum = '0;
    coin_sum   = '0;
    shown_q    = '0;
    redraw_q   = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset rates.
    // Display: pending redraw after reset, then unchanged, then forced.
    commands_waiting.push_back(command_word(OP_REFRESH, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_REFRESH, 2'b11, 4'hF, 8'hFF));
    commands_waiting.push_back(command_word(OP_FORCE, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_REFRESH, 2'b00, 4'h0, 8'h00));
    // Takes and a START scan with nothing in
    commands_waiting.push_back(command_word(OP_JOIN, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_SEAT, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_START, 2'b00, 4'hF, 8'h00));
    // Load above the cap, then scan the first and the last seat
    commands_waiting.push_back(command_word(OP_SET, 2'b00, 4'h0, 8'hFF));
    commands_waiting.push_back(command_word(OP_START, 2'b00, 4'hF, 8'h00));
    commands_waiting.push_back(command_word(OP_START, 2'b00, 4'h8, 8'h00));
    commands_waiting.push_back(command_word(OP_SEAT, 2'b00, 4'h0, 8'h00));
    // Coin price with no part coins: break a credit
    commands_waiting.push_back(command_word(OP_JOIN, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_REFRESH, 2'b00, 4'h0, 8'h00));
    // Unknown opcodes with every field bit set or clear
    commands_waiting.push_back(command_word(OP_FIRST_UNUSED, 2'b11, 4'hF, 8'hFF));
    commands_waiting.push_back(command_word(OP_LAST_UNUSED, 2'b00, 4'h0, 8'h00));
    // Two coins in one frame just under the cap: both clamp at the cap
    commands_waiting.push_back(command_word(OP_SET, 2'b00, 4'h0, 8'd98));
    push_ticks(2'b00, 4);
    push_ticks(2'b11, 1);
    push_ticks(2'b00, 1);
    commands_waiting.push_back(command_word(OP_START, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_BUYIN, 2'b00, 4'h0, 8'h00));
    commands_waiting.push_back(command_word(OP_CONT, 2'b00, 4'h0, 8'h00));
    drain();
    run_random(80, 0, 0);

    // Zero ratios store one; every take priced at a whole credit.
    set_rates(8'd0, 8'd0, 3'd7);
    run_random(90, 51, 0);
    run_random(30, 0, 0);

    // Widest ratios: credits always clamp at the cap.
    set_rates(8'd255, 8'd255, 3'd0);
    run_random(80, 0, 51);

    // Mixed pricing under idling on both sides.
    set_rates(8'd3, 8'd2, 3'd5);
    run_random(90, 36, 36);
    run_random(30, 0, 0);

    // Hold off the report side while commands keep coming: fill the block
    // and make it drop ready on the command side.
    set_rates(8'd2, 8'd40, 3'd2);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked++;
    run_random(100, 0, 0);
    run_random(40, 0, 51);

    // Hold limit: one chute just under it, the other exactly at it.
    set_rates(8'd1, 8'd1, 3'($urandom));
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_long_hold(int'(HOLD_LIMIT) - 1);
    drain();
    run_random(60, 36, 36);

    // Coin-sized ratios under idling on both sides.
    set_rates(8'd4, 8'd7, 3'd1);
    run_random(50, 51, 51);

    // Give the pipeline its latency to show any stray report.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reports_due.size() != 0) begin
      $error("%0d report words never arrived", reports_due.size());
      error_count++;
    end

    $display("Checked %0d reports for %0d command words over %0d rate settings.",
             reports_checked, words_sent, settings_run);
    $display("Saw %0d coins, %0d seat starts, %0d cycles of command stall under hold-off.",
             coins_seen, seats_started, backpressure_cycles);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: coin_credit_controller.f
src/ccc_pkg.sv
src/ccc_chan_if.sv
src/ccc_step.sv
src/coin_credit_controller.sv
test/coin_credit_controller_tb.sv
